FILE: hw/rtl/m4rm_pkg.sv
// Shared types and constants for the 4x4 matrix row multiplier.
`default_nettype none
package m4rm_pkg;

   localparam int DIM    = 4;
   localparam int ELEM_W = 32;
   localparam int ROW_W  = 2;
   localparam int PROD_W = 2 * ELEM_W;
   localparam int SUM_W  = PROD_W + 2;

   localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   // Request kinds carried in req_type
   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_MUL  = 1'b1
   } m4rm_req_kind_type;

   typedef logic [DIM-1:0][ELEM_W-1:0] m4rm_row_type;
   typedef m4rm_row_type [DIM-1:0]      m4rm_matrix_type;

   // Load enables for the lane pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } m4rm_stage_en_type;

   // What one column lane hands to the merge stage
   typedef struct packed {
      logic [ELEM_W-1:0] value;
      logic              sat;
   } m4rm_lane_out_type;

endpackage
`default_nettype wire

FILE: hw/rtl/m4rm_if.sv
// Valid/ready channel interfaces for request and response beats.
`default_nettype none
interface m4rm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic [m4rm_pkg::ROW_W-1:0]          row_index;
   logic signed [m4rm_pkg::ELEM_W-1:0]  elem_0;
   logic signed [m4rm_pkg::ELEM_W-1:0]  elem_1;
   logic signed [m4rm_pkg::ELEM_W-1:0]  elem_2;
   logic signed [m4rm_pkg::ELEM_W-1:0]  elem_3;

   modport source (output valid, req_type, row_index, elem_0, elem_1, elem_2, elem_3,
                   input ready);
   modport sink   (input valid, req_type, row_index, elem_0, elem_1, elem_2, elem_3,
                   output ready);
endinterface

interface m4rm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [m4rm_pkg::ROW_W-1:0]          out_row;
   logic signed [m4rm_pkg::ELEM_W-1:0]  prod_0;
   logic signed [m4rm_pkg::ELEM_W-1:0]  prod_1;
   logic signed [m4rm_pkg::ELEM_W-1:0]  prod_2;
   logic signed [m4rm_pkg::ELEM_W-1:0]  prod_3;
   logic                                sat_flag;

   modport source (output valid, out_row, prod_0, prod_1, prod_2, prod_3, sat_flag,
                   input ready);
   modport sink   (input valid, out_row, prod_0, prod_1, prod_2, prod_3, sat_flag,
                   output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/m4rm_matrix_store.sv
// Right-matrix register file: row write, all sixteen entries visible.
`default_nettype none
module m4rm_matrix_store #(
   parameter int FRAC_BITS = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                wr_en,
   input  wire  [m4rm_pkg::ROW_W-1:0]         wr_row,
   input  wire  m4rm_pkg::m4rm_row_type       wr_data,
   output m4rm_pkg::m4rm_matrix_type          matrix
);

   localparam logic [m4rm_pkg::ELEM_W-1:0] ONE =
      m4rm_pkg::ELEM_W'(64'd1 << FRAC_BITS);

   m4rm_pkg::m4rm_matrix_type matrix_ff;
   m4rm_pkg::m4rm_matrix_type matrix_in;

   // Replace the addressed row, keep the others
   always_comb begin
      matrix_in = matrix_ff;
      if (wr_en) begin
         matrix_in[wr_row] = wr_data;
      end
   end

   // Reset to identity
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < m4rm_pkg::DIM; r++) begin
            for (int c = 0; c < m4rm_pkg::DIM; c++) begin
               matrix_ff[r][c] <= (r == c) ? ONE : '0;
            end
         end
      end else begin
         matrix_ff <= matrix_in;
      end
   end

   assign matrix = matrix_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/m4rm_lane.sv
// One column lane: four products, two-level sum, shift and saturate.
`default_nettype none
module m4rm_lane #(
   parameter int FRAC_BITS = 16
) (
   input  wire                                clock,
   input  wire  m4rm_pkg::m4rm_stage_en_type  en,
   input  wire  m4rm_pkg::m4rm_row_type       l_row,
   input  wire  m4rm_pkg::m4rm_row_type       r_col,
   output m4rm_pkg::m4rm_lane_out_type        result
);

   localparam int PW = m4rm_pkg::PROD_W;
   localparam int SW = m4rm_pkg::SUM_W;
   localparam int EW = m4rm_pkg::ELEM_W;

   logic signed [PW-1:0]   prod_ff [m4rm_pkg::DIM];
   logic signed [PW-1:0]   prod_in [m4rm_pkg::DIM];
   logic signed [PW:0]     pair_ff [2];
   logic signed [PW:0]     pair_in [2];
   logic signed [SW-1:0]   sum_ff;
   logic signed [SW-1:0]   sum_in;
   logic signed [SW-1:0]   shifted;
   logic [SW-EW:0]         top_bits;
   logic                   sat;

   // Stage 1: one signed multiply per term
   always_comb begin
      for (int k = 0; k < m4rm_pkg::DIM; k++) begin
         prod_in[k] = $signed(l_row[k]) * $signed(r_col[k]);
      end
   end

   // Stage 2: pairwise sums
   assign pair_in[0] = (PW+1)'(prod_ff[0]) + (PW+1)'(prod_ff[1]);
   assign pair_in[1] = (PW+1)'(prod_ff[2]) + (PW+1)'(prod_ff[3]);

   // Stage 3: exact total
   assign sum_in = SW'(pair_ff[0]) + SW'(pair_ff[1]);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff <= prod_in;
      end
      if (en.s2) begin
         pair_ff <= pair_in;
      end
      if (en.s3) begin
         sum_ff <= sum_in;
      end
   end

   // Drop fraction bits (floor), then clamp to 32 bits
   assign shifted  = sum_ff >>> FRAC_BITS;
   assign top_bits = shifted[SW-1:EW-1];
   assign sat      = !((&top_bits) || (~|top_bits));

   always_comb begin
      result.sat = sat;
      if (!sat) begin
         result.value = shifted[EW-1:0];
      end else if (shifted[SW-1]) begin
         result.value = m4rm_pkg::SAT_MIN;
      end else begin
         result.value = m4rm_pkg::SAT_MAX;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/m4rm_merge.sv
// Merge stage: gathers the four lane results into the response register.
`default_nettype none
module m4rm_merge (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                in_valid,
   input  wire  [m4rm_pkg::ROW_W-1:0]         in_row,
   input  wire  m4rm_pkg::m4rm_lane_out_type  lanes [m4rm_pkg::DIM],
   output logic                               in_ready,
   m4rm_rsp_if.source                         rsp
);

   logic                                valid_ff;
   logic                                valid_in;
   logic [m4rm_pkg::ROW_W-1:0]          row_ff;
   logic [m4rm_pkg::DIM-1:0][m4rm_pkg::ELEM_W-1:0] prod_ff;
   logic                                sat_ff;
   logic                                sat_in;

   assign in_ready = !valid_ff || rsp.ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Combine lane saturation flags
   always_comb begin
      sat_in = 1'b0;
      for (int j = 0; j < m4rm_pkg::DIM; j++) begin
         sat_in = sat_in | lanes[j].sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload whenever the register is free
   always_ff @(posedge clock) begin
      if (in_ready) begin
         row_ff <= in_row;
         sat_ff <= sat_in;
         for (int j = 0; j < m4rm_pkg::DIM; j++) begin
            prod_ff[j] <= lanes[j].value;
         end
      end
   end

   assign rsp.valid    = valid_ff;
   assign rsp.out_row  = row_ff;
   assign rsp.prod_0   = prod_ff[0];
   assign rsp.prod_1   = prod_ff[1];
   assign rsp.prod_2   = prod_ff[2];
   assign rsp.prod_3   = prod_ff[3];
   assign rsp.sat_flag = sat_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/matrix4x4_row_multiply_top.sv
// Top level of the 4x4 Q16.16 matrix row multiplier.
//
//   channel  dir  beat contents
//   -------  ---  -----------------------------------------------------
//   req_ch   in   req_type, row_index, elem_0..elem_3 (load or multiply)
//   rsp_ch   out  out_row, prod_0..prod_3, sat_flag (multiply only)
//
// One beat per cycle in while rsp_ch does not stall; a multiply beat passes the
// multiply, pair add, final add and merge registers before its response.
// Load beats update the right matrix at acceptance and occupy no stage.
// Reset clears the pipeline and sets the right matrix to identity.
// Stalls on rsp_ch back up stage by stage; empty stages still take beats.
`default_nettype none
module matrix4x4_row_multiply_top #(
   parameter int FRAC_BITS = 16
) (
   input  wire          clock,
   input  wire          reset,
   m4rm_req_if.sink     req_ch,
   m4rm_rsp_if.source   rsp_ch
);

   localparam int DIM = m4rm_pkg::DIM;

   logic                              req_fire;
   logic                              is_mul;
   logic                              is_load;
   logic                              rdy1, rdy2, rdy3;
   logic                              merge_ready;
   logic                              v1_ff, v2_ff, v3_ff;
   logic                              v1_in, v2_in, v3_in;
   logic [m4rm_pkg::ROW_W-1:0]        row1_ff, row2_ff, row3_ff;
   m4rm_pkg::m4rm_stage_en_type       stage_en;
   m4rm_pkg::m4rm_row_type            l_row;
   m4rm_pkg::m4rm_matrix_type         matrix;
   m4rm_pkg::m4rm_lane_out_type       lane_out [DIM];

   assign l_row   = {req_ch.elem_3, req_ch.elem_2, req_ch.elem_1, req_ch.elem_0};
   assign is_mul  = (req_ch.req_type == m4rm_pkg::REQ_MUL);
   assign is_load = (req_ch.req_type == m4rm_pkg::REQ_LOAD);

   // Ready chain: a stage advances if empty or its successor advances
   assign rdy3 = !v3_ff || merge_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ch.ready = rdy1;
   assign req_fire     = req_ch.valid && rdy1;

   assign stage_en = '{s1: rdy1, s2: rdy2, s3: rdy3};

   assign v1_in = rdy1 ? (req_fire && is_mul) : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Carry the row number alongside the lane data
   always_ff @(posedge clock) begin
      if (rdy1) begin
         row1_ff <= req_ch.row_index;
      end
      if (rdy2) begin
         row2_ff <= row1_ff;
      end
      if (rdy3) begin
         row3_ff <= row2_ff;
      end
   end

   m4rm_matrix_store #(.FRAC_BITS(FRAC_BITS)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_fire && is_load),
      .wr_row  (req_ch.row_index),
      .wr_data (l_row),
      .matrix  (matrix)
   );

   // One lane per product column, fed with that column of the right matrix
   for (genvar j = 0; j < DIM; j++) begin : g_lane
      m4rm_pkg::m4rm_row_type r_col;
      always_comb begin
         for (int k = 0; k < DIM; k++) begin
            r_col[k] = matrix[k][j];
         end
      end

      m4rm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock  (clock),
         .en     (stage_en),
         .l_row  (l_row),
         .r_col  (r_col),
         .result (lane_out[j])
      );
   end

   m4rm_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v3_ff),
      .in_row   (row3_ff),
      .lanes    (lane_out),
      .in_ready (merge_ready),
      .rsp      (rsp_ch)
   );

   // A flagged response carries at least one clamped column
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.sat_flag) |->
         (rsp_ch.prod_0 == m4rm_pkg::SAT_MAX || rsp_ch.prod_0 == m4rm_pkg::SAT_MIN ||
          rsp_ch.prod_1 == m4rm_pkg::SAT_MAX || rsp_ch.prod_1 == m4rm_pkg::SAT_MIN ||
          rsp_ch.prod_2 == m4rm_pkg::SAT_MAX || rsp_ch.prod_2 == m4rm_pkg::SAT_MIN ||
          rsp_ch.prod_3 == m4rm_pkg::SAT_MAX || rsp_ch.prod_3 == m4rm_pkg::SAT_MIN))
      else $error("sat_flag set without a clamped column");

   // Load beats never enter the pipeline
   a_load_no_stage: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_load) |=> !v1_ff)
      else $error("load beat occupied the multiply stage");

   // Multiply beats always enter the pipeline
   a_mul_stage: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_mul) |=> v1_ff)
      else $error("multiply beat lost at entry");

   // Reset leaves the right matrix at identity
   a_reset_identity: assert property (@(posedge clock)
      reset |=> (matrix[0][0] == m4rm_pkg::ELEM_W'(64'd1 << FRAC_BITS) &&
                 matrix[0][1] == '0))
      else $error("right matrix not identity after reset");

endmodule
`default_nettype wire

FILE: verif/tb_matrix4x4_row_multiply_top.sv
// Testbench for the 4x4 Q16.16 matrix row multiplier: directed and random row beats.
`default_nettype none
module tb_matrix4x4_row_multiply_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS    = 16;
   localparam int RANDOM_BEATS = 1900;
   localparam int PHASE_BEATS  = 150;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_MAX   = 10;

   localparam int DIM    = m4rm_pkg::DIM;
   localparam int ELEM_W = m4rm_pkg::ELEM_W;
   localparam int ROW_W  = m4rm_pkg::ROW_W;
   localparam int SUM_W  = m4rm_pkg::SUM_W;

   localparam logic signed [SUM_W-1:0] Q_TOP    = SUM_W'(64'sh7FFFFFFF);
   localparam logic signed [SUM_W-1:0] Q_BOTTOM = -SUM_W'(64'sh80000000);

   localparam logic [ELEM_W-1:0] Q_ONE     = 32'h0001_0000;
   localparam logic [ELEM_W-1:0] Q_NEG_ONE = 32'hFFFF_0000;
   localparam logic [ELEM_W-1:0] RAW_ONE   = 32'h0000_0001;
   localparam logic [ELEM_W-1:0] RAW_NEG   = 32'hFFFF_FFFF;

   // Idle patterns, stepped through as beats go out
   typedef enum logic [1:0] {
      FLOW_FREE    = 2'd0,
      FLOW_SRC_GAP = 2'd1,
      FLOW_SNK_GAP = 2'd2,
      FLOW_BOTH    = 2'd3
   } flow_mode_type;

   typedef struct packed {
      m4rm_pkg::m4rm_req_kind_type kind;
      logic [ROW_W-1:0]            row;
      m4rm_pkg::m4rm_row_type      elems;
   } row_beat_type;

   typedef struct packed {
      logic [ROW_W-1:0]       row;
      m4rm_pkg::m4rm_row_type prod;
      logic                   sat;
   } product_row_type;

   logic clock;
   logic reset;

   m4rm_req_if req_ch();
   m4rm_rsp_if rsp_ch();

   matrix4x4_row_multiply_top #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   row_beat_type              row_beats[$];
   product_row_type           product_rows[$];
   m4rm_pkg::m4rm_matrix_type right_rows;
   flow_mode_type             flow_mode;

   int beats_sent;
   int loads_seen;
   int muls_seen;
   int rows_checked;
   int sat_rows;
   int mismatch_count;
   int cycle_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One product column: exact wide sum, arithmetic shift, saturate to 32 bits
   function automatic void product_column(input m4rm_pkg::m4rm_row_type lrow, input int col,
                                          output logic [ELEM_W-1:0] value,
                                          output logic sat);
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] shifted;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
         acc = acc + SUM_W'($signed(lrow[k])) * SUM_W'($signed(right_rows[k][col]));
      end
      shifted = acc >>> FRAC_BITS;
      sat = 1'b0;
      if (shifted > Q_TOP) begin
         value = m4rm_pkg::SAT_MAX;
         sat   = 1'b1;
      end else if (shifted < Q_BOTTOM) begin
         value = m4rm_pkg::SAT_MIN;
         sat   = 1'b1;
      end else begin
         value = shifted[ELEM_W-1:0];
      end
   endfunction

   // Update the right matrix on a load, queue the product row on a multiply
   task automatic apply_row_beat(input row_beat_type beat);
      product_row_type want;
      logic            col_sat;
      if (beat.kind == m4rm_pkg::REQ_LOAD) begin
         right_rows[beat.row] = beat.elems;
         loads_seen++;
      end else begin
         want.row = beat.row;
         want.sat = 1'b0;
         for (int c = 0; c < DIM; c++) begin
            product_column(beat.elems, c, want.prod[c], col_sat);
            want.sat = want.sat | col_sat;
         end
         product_rows.push_back(want);
         muls_seen++;
      end
   endtask

   task automatic note_mismatch(input string field, input logic [ELEM_W-1:0] want,
                                input logic [ELEM_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("tb: mismatch on %s at %0t: expected %h, got %h", field, $time, want, got);
   endtask

   function automatic logic [ELEM_W-1:0] corner_elem();
      case ($urandom_range(6))
         0: corner_elem = m4rm_pkg::SAT_MAX;
         1: corner_elem = m4rm_pkg::SAT_MIN;
         2: corner_elem = '0;
         3: corner_elem = Q_ONE;
         4: corner_elem = Q_NEG_ONE;
         5: corner_elem = RAW_ONE;
         default: corner_elem = RAW_NEG;
      endcase
   endfunction

   // Modest Q16.16 values so products stay in range, as often as full range, plus corners
   function automatic logic [ELEM_W-1:0] pick_elem();
      case ($urandom_range(9))
         0, 1, 2, 3: pick_elem = ELEM_W'(int'($urandom_range(20'hFFFFF)) - 32'sh80000);
         4, 5:       pick_elem = corner_elem();
         default:    pick_elem = $urandom;
      endcase
   endfunction

   task automatic push_beat(input m4rm_pkg::m4rm_req_kind_type kind,
                            input logic [ROW_W-1:0] row,
                            input logic [ELEM_W-1:0] e0, input logic [ELEM_W-1:0] e1,
                            input logic [ELEM_W-1:0] e2, input logic [ELEM_W-1:0] e3);
      row_beat_type beat;
      beat.kind  = kind;
      beat.row   = row;
      beat.elems = {e3, e2, e1, e0};
      row_beats.push_back(beat);
   endtask

   function automatic logic hold_source();
      case (flow_mode)
         FLOW_SRC_GAP: hold_source = $urandom_range(99) < 50;
         FLOW_BOTH:    hold_source = $urandom_range(99) < 11;
         default:      hold_source = 1'b0;
      endcase
   endfunction

   function automatic logic hold_sink();
      case (flow_mode)
         FLOW_SNK_GAP: hold_sink = $urandom_range(99) < 50;
         FLOW_BOTH:    hold_sink = $urandom_range(99) < 11;
         default:      hold_sink = 1'b0;
      endcase
   endfunction

   // Drive request beats; advance only once the current beat is taken
   always @(posedge clock) begin : drive_req
      row_beat_type beat;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (row_beats.size() != 0 && !hold_source()) begin
            beat = row_beats.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.req_type  <= beat.kind;
            req_ch.row_index <= beat.row;
            req_ch.elem_0    <= beat.elems[0];
            req_ch.elem_1    <= beat.elems[1];
            req_ch.elem_2    <= beat.elems[2];
            req_ch.elem_3    <= beat.elems[3];
            beats_sent       <= beats_sent + 1;
            flow_mode        <= flow_mode_type'(((beats_sent + 1) / PHASE_BEATS) % 4);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Stall the response channel at random
   always @(posedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= !hold_sink();
   end

   // Predict from every accepted request beat
   always @(posedge clock) begin : watch_req
      row_beat_type beat;
      if (!reset && req_ch.valid && req_ch.ready) begin
         beat.kind  = m4rm_pkg::m4rm_req_kind_type'(req_ch.req_type);
         beat.row   = req_ch.row_index;
         beat.elems = {req_ch.elem_3, req_ch.elem_2, req_ch.elem_1, req_ch.elem_0};
         apply_row_beat(beat);
      end
   end

   // Check every accepted response beat against the oldest prediction
   always @(posedge clock) begin : watch_rsp
      product_row_type        want;
      m4rm_pkg::m4rm_row_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = {rsp_ch.prod_3, rsp_ch.prod_2, rsp_ch.prod_1, rsp_ch.prod_0};
         if (product_rows.size() == 0) begin
            note_mismatch("unexpected beat, prod_0", '0, got[0]);
         end else begin
            want = product_rows.pop_front();
            rows_checked++;
            if (want.sat)
               sat_rows++;
            if (rsp_ch.out_row !== want.row)
               note_mismatch("out_row", ELEM_W'(want.row), ELEM_W'(rsp_ch.out_row));
            for (int c = 0; c < DIM; c++) begin
               if (got[c] !== want.prod[c])
                  note_mismatch($sformatf("prod_%0d", c), want.prod[c], got[c]);
            end
            if (rsp_ch.sat_flag !== want.sat)
               note_mismatch("sat_flag", ELEM_W'(want.sat), ELEM_W'(rsp_ch.sat_flag));
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.req_type  = m4rm_pkg::REQ_LOAD;
      req_ch.row_index = '0;
      req_ch.elem_0    = '0;
      req_ch.elem_1    = '0;
      req_ch.elem_2    = '0;
      req_ch.elem_3    = '0;
      rsp_ch.ready     = 1'b0;
      flow_mode        = FLOW_FREE;
      beats_sent       = 0;
      loads_seen       = 0;
      muls_seen        = 0;
      rows_checked     = 0;
      sat_rows         = 0;
      mismatch_count   = 0;
      cycle_count      = 0;

      // Right matrix starts as identity
      right_rows = '0;
      for (int i = 0; i < DIM; i++)
         right_rows[i][i] = Q_ONE;

      // Identity passes each row through, extremes included
      push_beat(m4rm_pkg::REQ_MUL, 2'd0, m4rm_pkg::SAT_MAX, m4rm_pkg::SAT_MIN, '0, RAW_ONE);
      push_beat(m4rm_pkg::REQ_MUL, 2'd1, Q_ONE, Q_NEG_ONE, RAW_NEG, m4rm_pkg::SAT_MAX);
      push_beat(m4rm_pkg::REQ_MUL, 2'd2, m4rm_pkg::SAT_MIN, m4rm_pkg::SAT_MIN,
                m4rm_pkg::SAT_MAX, m4rm_pkg::SAT_MAX);
      push_beat(m4rm_pkg::REQ_MUL, 2'd3, '0, '0, '0, '0);
      // One row of maximums: positive and negative saturation
      push_beat(m4rm_pkg::REQ_LOAD, 2'd2, m4rm_pkg::SAT_MAX, m4rm_pkg::SAT_MAX,
                m4rm_pkg::SAT_MAX, m4rm_pkg::SAT_MAX);
      push_beat(m4rm_pkg::REQ_MUL, 2'd2, m4rm_pkg::SAT_MAX, m4rm_pkg::SAT_MAX,
                m4rm_pkg::SAT_MAX, m4rm_pkg::SAT_MAX);
      push_beat(m4rm_pkg::REQ_MUL, 2'd1, m4rm_pkg::SAT_MIN, m4rm_pkg::SAT_MIN,
                m4rm_pkg::SAT_MIN, m4rm_pkg::SAT_MIN);
      // Other rows untouched by the load
      push_beat(m4rm_pkg::REQ_MUL, 2'd0, Q_ONE, Q_ONE, '0, Q_ONE);
      // All minimums: the sum needs more than 64 bits
      for (int r = 0; r < DIM; r++)
         push_beat(m4rm_pkg::REQ_LOAD, ROW_W'(r), m4rm_pkg::SAT_MIN, m4rm_pkg::SAT_MIN,
                   m4rm_pkg::SAT_MIN, m4rm_pkg::SAT_MIN);
      push_beat(m4rm_pkg::REQ_MUL, 2'd3, m4rm_pkg::SAT_MIN, m4rm_pkg::SAT_MIN,
                m4rm_pkg::SAT_MIN, m4rm_pkg::SAT_MIN);
      // Large terms that cancel to an in-range result
      push_beat(m4rm_pkg::REQ_MUL, 2'd2, m4rm_pkg::SAT_MAX, m4rm_pkg::SAT_MIN,
                m4rm_pkg::SAT_MAX, m4rm_pkg::SAT_MIN);
      // Shift rounds toward minus infinity
      push_beat(m4rm_pkg::REQ_LOAD, 2'd0, RAW_ONE, RAW_ONE, RAW_ONE, RAW_ONE);
      push_beat(m4rm_pkg::REQ_LOAD, 2'd1, '0, '0, '0, '0);
      push_beat(m4rm_pkg::REQ_LOAD, 2'd2, '0, '0, '0, '0);
      push_beat(m4rm_pkg::REQ_LOAD, 2'd3, '0, '0, '0, '0);
      push_beat(m4rm_pkg::REQ_MUL, 2'd0, RAW_NEG, '0, '0, '0);
      push_beat(m4rm_pkg::REQ_MUL, 2'd1, RAW_ONE, '0, '0, '0);
      // Restore identity before the random part
      push_beat(m4rm_pkg::REQ_LOAD, 2'd0, Q_ONE, '0, '0, '0);
      push_beat(m4rm_pkg::REQ_LOAD, 2'd1, '0, Q_ONE, '0, '0);
      push_beat(m4rm_pkg::REQ_LOAD, 2'd2, '0, '0, Q_ONE, '0);
      push_beat(m4rm_pkg::REQ_LOAD, 2'd3, '0, '0, '0, Q_ONE);

      // Random loads and multiplies, weighted toward multiplies
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         push_beat(($urandom_range(99) < 30) ? m4rm_pkg::REQ_LOAD : m4rm_pkg::REQ_MUL,
                   ROW_W'($urandom_range(DIM - 1)),
                   pick_elem(), pick_elem(), pick_elem(), pick_elem());
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Hold until every beat is out and every product row is back
      @(negedge clock);
      while (row_beats.size() != 0 || req_ch.valid || product_rows.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("tb: %0d loads and %0d multiplies sent under four idle patterns",
               loads_seen, muls_seen);
      $display("tb: %0d product rows checked, %0d saturated, %0d mismatches",
               rows_checked, sat_rows, mismatch_count);
      if (mismatch_count == 0 && product_rows.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
`default_nettype wire
